// ===== rtl/cfc_pkg.sv =====
package cfc_pkg;

    // Sample storage and comparison widths
    localparam int MAX_SAMPLES = 65536;
    localparam int VALUE_BITS  = 32;
    localparam int FIELD_BITS  = 32;
    localparam int CMP_BITS    = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam int INDEX_BITS  = 16;
    localparam int INDEX_LIMIT = (MAX_SAMPLES < 65536) ? MAX_SAMPLES : 65536;
    localparam logic [INDEX_BITS-1:0] LAST_INDEX = INDEX_BITS'(INDEX_LIMIT - 1);

    // Result slots produced by one sample: previous-sample slot, own feature, end point
    localparam int NUM_SLOTS = 3;

    // Configuration register indexes
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INCLUDE_ZERO      = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DETECT_INFLECTION = 1'b1;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_END     = 2'd1,
        KIND_FEATURE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        FEAT_NONE           = 3'd0,
        FEAT_MAX            = 3'd1,
        FEAT_MIN            = 3'd2,
        FEAT_INFLECTION     = 3'd3,
        FEAT_MAX_AFTER_GAP  = 3'd4,
        FEAT_MIN_AFTER_GAP  = 3'd5,
        FEAT_MAX_BEFORE_GAP = 3'd6,
        FEAT_MIN_BEFORE_GAP = 3'd7
    } t_feature;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] sample_value;
        logic signed [FIELD_BITS-1:0] sample_slope;
        logic signed [FIELD_BITS-1:0] report_value;
        logic                         sample_valid;
        logic                         sweep_end;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_BITS-1:0]        point_index;
        logic signed [FIELD_BITS-1:0] point_value;
        logic [1:0]                   point_kind;
        logic                         is_zero;
        logic [2:0]                   feature;
        logic                         last_of_run;
    } t_out_item;

    // One windowed sample as the classifier sees it
    typedef struct packed {
        logic signed [CMP_BITS-1:0]   v;
        logic signed [CMP_BITS-1:0]   s;
        logic signed [FIELD_BITS-1:0] r;
        logic                         ok;
    } t_smp;

    // Work held in the stage register for one accepted sample
    typedef struct packed {
        t_smp                  cur;
        t_smp                  prv;
        t_smp                  old;
        logic [INDEX_BITS-1:0] idx;
        logic                  last;
    } t_job;

endpackage

// ===== rtl/cfc_front.sv =====
module cfc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  cfc_pkg::t_in_item i_in_data,
    output logic              o_in_ready,
    input  logic              i_retire,
    output logic              o_job_valid,
    output cfc_pkg::t_job     o_job
);
    import cfc_pkg::*;

    logic                  r_busy;
    t_job                  r_job;
    logic                  r_started;
    logic [INDEX_BITS-1:0] r_counter;
    t_smp                  r_win0;
    t_smp                  r_win1;

    logic                  accept;
    logic [INDEX_BITS-1:0] idx;
    logic                  last;
    t_smp                  cur;
    t_job                  n_job;

    assign o_in_ready = !r_busy || i_retire;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        idx    = r_started ? r_counter : '0;
        last   = i_in_data.sweep_end || (idx == LAST_INDEX);
        cur.v  = i_in_data.sample_value[CMP_BITS-1:0];
        cur.s  = i_in_data.sample_slope[CMP_BITS-1:0];
        cur.r  = i_in_data.report_value;
        cur.ok = i_in_data.sample_valid;
        n_job.cur  = cur;
        n_job.prv  = r_win0;
        n_job.old  = r_win1;
        n_job.idx  = idx;
        n_job.last = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_started <= 1'b0;
            r_counter <= '0;
        end else begin
            if (accept) begin
                r_busy    <= 1'b1;
                r_started <= !last;
                r_counter <= last ? '0 : INDEX_BITS'(idx + 1'b1);
            end else if (i_retire) begin
                r_busy <= 1'b0;
            end
        end
    end

    // shift the window on every accepted sample, invalid ones too
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job  <= n_job;
            r_win1 <= r_win0;
            r_win0 <= cur;
        end
    end

    assign o_job_valid = r_busy;
    assign o_job       = r_job;

endmodule

// ===== rtl/cfc_classify.sv =====
module cfc_classify (
    input  cfc_pkg::t_smp     i_c,
    input  cfc_pkg::t_smp     i_p,
    input  cfc_pkg::t_smp     i_n,
    input  logic              i_include_zero,
    input  logic              i_detect_inflection,
    output logic              o_zero,
    output cfc_pkg::t_feature o_feature
);
    import cfc_pkg::*;

    always_comb begin
        o_zero    = 1'b0;
        o_feature = FEAT_NONE;
        if (i_c.ok) begin
            if (!i_p.ok && i_n.ok) begin
                if (i_c.v > i_n.v) begin
                    o_feature = FEAT_MAX_AFTER_GAP;
                end else if (i_c.v < i_n.v) begin
                    o_feature = FEAT_MIN_AFTER_GAP;
                end
            end else if (i_p.ok && !i_n.ok) begin
                if (i_c.v > i_p.v) begin
                    o_feature = FEAT_MAX_BEFORE_GAP;
                end else if (i_c.v < i_p.v) begin
                    o_feature = FEAT_MIN_BEFORE_GAP;
                end
            end else if (i_p.ok && i_n.ok) begin
                if (i_include_zero) begin
                    // exact zero, or a sign change toward a nonzero neighbor
                    if (i_c.v == '0) begin
                        o_zero = 1'b1;
                    end else if ((i_n.v != '0)
                                 && (i_c.v[CMP_BITS-1] != i_n.v[CMP_BITS-1])) begin
                        o_zero = 1'b1;
                    end
                end
                if (i_c.v > i_p.v && i_c.v > i_n.v) begin
                    o_feature = FEAT_MAX;
                end else if (i_c.v < i_p.v && i_c.v < i_n.v) begin
                    o_feature = FEAT_MIN;
                end else if (i_detect_inflection) begin
                    if ((i_c.s < i_p.s && i_c.s < i_n.s)
                        || (i_c.s > i_p.s && i_c.s > i_n.s)) begin
                        o_feature = FEAT_INFLECTION;
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/curve_feature_classifier_unit.sv =====
// Curve feature classifier. Feed the samples of a sweep in order, one
// transaction per sample; mark the final sample with sweep_end (a sample at
// the last index the counter allows also closes the sweep). Each sample is
// classified when its right neighbor arrives, so the results of a sample
// trail it by one transaction; the final sample of a sweep yields the
// classification of the two last samples plus the end point, and the first
// yields the start point. A sample yields zero to three result transactions,
// and last_of_run flags the final one of each group. Rate: one sample per
// cycle while every sample yields at most one result and the consumer is
// ready; a sample with several results holds the stage register until all
// have moved out, because the single output register drains one result per
// cycle, and only while the consumer takes them. A sample with no result
// still passes through the stage register. A sample is taken into the stage
// register at acceptance, and its first result is then loaded into the
// output register once that is free. The output register lets a new sample
// enter while a finished result waits for the consumer.
// Configuration writes take effect at once and are meant for idle periods.
module curve_feature_classifier_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  cfc_pkg::t_in_item                    i_in_data,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output cfc_pkg::t_out_item                   o_out_data,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [cfc_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [cfc_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import cfc_pkg::*;

    logic r_include_zero;
    logic r_detect_inflection;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_include_zero      <= 1'b1;
            r_detect_inflection <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INCLUDE_ZERO:      r_include_zero      <= i_cfg_data[0];
                CFG_DETECT_INFLECTION: r_detect_inflection <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic job_valid;
    t_job job;
    logic retire;

    cfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .i_retire    (retire),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    // Previous sample, against its left neighbor (itself when it is sample 0)
    t_smp     prev_left;
    logic     prev_zero;
    t_feature prev_feat;
    // Current sample at the end of a sweep: right edge clamped to itself
    t_smp     cur_left;
    logic     cur_zero;
    t_feature cur_feat;

    assign prev_left = (job.idx == INDEX_BITS'(1)) ? job.prv : job.old;
    assign cur_left  = (job.idx == '0) ? job.cur : job.prv;

    cfc_classify u_class_prev (
        .i_c                 (job.prv),
        .i_p                 (prev_left),
        .i_n                 (job.cur),
        .i_include_zero      (r_include_zero),
        .i_detect_inflection (r_detect_inflection),
        .o_zero              (prev_zero),
        .o_feature           (prev_feat)
    );

    cfc_classify u_class_cur (
        .i_c                 (job.cur),
        .i_p                 (cur_left),
        .i_n                 (job.cur),
        .i_include_zero      (r_include_zero),
        .i_detect_inflection (r_detect_inflection),
        .o_zero              (cur_zero),
        .o_feature           (cur_feat)
    );

    // Build the result slots of the staged sample, in emission order
    t_out_item              slot [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   slot_mask;

    always_comb begin
        // slot 0: start point on sample 0, else the previous sample's feature
        if (job.idx == '0) begin
            slot[0].point_index = '0;
            slot[0].point_value = job.cur.r;
            slot[0].point_kind  = KIND_START;
            slot[0].is_zero     = 1'b0;
            slot[0].feature     = FEAT_NONE;
            slot_mask[0]        = 1'b1;
        end else begin
            slot[0].point_index = INDEX_BITS'(job.idx - 1'b1);
            slot[0].point_value = job.prv.r;
            slot[0].point_kind  = KIND_FEATURE;
            slot[0].is_zero     = prev_zero;
            slot[0].feature     = prev_feat;
            slot_mask[0]        = prev_zero || (prev_feat != FEAT_NONE);
        end
        slot[0].last_of_run = 1'b0;

        // slot 1: the final sample's own feature
        slot[1].point_index = job.idx;
        slot[1].point_value = job.cur.r;
        slot[1].point_kind  = KIND_FEATURE;
        slot[1].is_zero     = cur_zero;
        slot[1].feature     = cur_feat;
        slot[1].last_of_run = 1'b0;
        slot_mask[1]        = job.last && (cur_zero || (cur_feat != FEAT_NONE));

        // slot 2: end point
        slot[2].point_index = job.idx;
        slot[2].point_value = job.cur.r;
        slot[2].point_kind  = KIND_END;
        slot[2].is_zero     = 1'b0;
        slot[2].feature     = FEAT_NONE;
        slot[2].last_of_run = 1'b0;
        slot_mask[2]        = job.last;
    end

    // Drain the slots through the output register, lowest first
    logic [NUM_SLOTS-1:0] r_done;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [NUM_SLOTS-1:0] remaining;
    logic [NUM_SLOTS-1:0] pick;
    logic                 out_free;
    logic                 load;
    t_out_item            n_out;

    always_comb begin
        remaining = job_valid ? (slot_mask & ~r_done) : '0;
        pick      = remaining & (~remaining + 1'b1);
        n_out     = slot[0];
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (pick[i]) begin
                n_out = slot[i];
            end
        end
        n_out.last_of_run = ((remaining & ~pick) == '0);
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign load     = out_free && (remaining != '0);
    // retire the staged sample once its last result moves out, or at once if it has none
    assign retire   = job_valid && ((remaining == '0) || (load && ((remaining & ~pick) == '0)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (retire) begin
                r_done <= '0;
            end else if (load) begin
                r_done <= r_done | pick;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== bench/cfc_point_check.sv =====
module cfc_point_check (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  cfc_pkg::t_in_item                  i_in_data,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  cfc_pkg::t_out_item                 i_out_data,
    input  logic                               i_cfg_we,
    input  logic [cfc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [cfc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked
);
    import cfc_pkg::*;

    typedef struct packed {
        logic     zero;
        t_feature feat;
    } t_label;

    t_out_item             expected_points[$];
    logic [INDEX_BITS-1:0] next_index = '0;
    logic                  in_sweep   = 1'b0;
    t_smp                  prev_smp   = '0;
    t_smp                  older_smp  = '0;
    logic                  zero_on    = 1'b1;
    logic                  infl_on    = 1'b0;
    int                    fail_n     = 0;
    int                    checked_n  = 0;

    function automatic t_label label_sample(t_smp c, t_smp p, t_smp n);
        t_label                     lab;
        logic signed [CMP_BITS-1:0] cv, pv, nv, cs, ps, ns;
        lab.zero = 1'b0;
        lab.feat = FEAT_NONE;
        cv = c.v;
        pv = p.v;
        nv = n.v;
        cs = c.s;
        ps = p.s;
        ns = n.s;
        if (!c.ok) return lab;
        if (!p.ok && n.ok) begin
            if (cv > nv) lab.feat = FEAT_MAX_AFTER_GAP;
            else if (cv < nv) lab.feat = FEAT_MIN_AFTER_GAP;
        end else if (p.ok && !n.ok) begin
            if (cv > pv) lab.feat = FEAT_MAX_BEFORE_GAP;
            else if (cv < pv) lab.feat = FEAT_MIN_BEFORE_GAP;
        end else if (p.ok && n.ok) begin
            if (zero_on) begin
                if (cv == 0) lab.zero = 1'b1;
                else if (nv != 0 && ((cv < 0) != (nv < 0))) lab.zero = 1'b1;
            end
            if (cv > pv && cv > nv) lab.feat = FEAT_MAX;
            else if (cv < pv && cv < nv) lab.feat = FEAT_MIN;
            else if (infl_on && ((cs < ps && cs < ns) || (cs > ps && cs > ns)))
                lab.feat = FEAT_INFLECTION;
        end
        return lab;
    endfunction

    task automatic add_point(logic [INDEX_BITS-1:0] idx, logic signed [FIELD_BITS-1:0] r,
                             t_kind kind, logic zero, t_feature feat);
        t_out_item pt;
        pt.point_index = idx;
        pt.point_value = r;
        pt.point_kind  = kind;
        pt.is_zero     = zero;
        pt.feature     = feat;
        pt.last_of_run = 1'b0;
        expected_points.push_back(pt);
    endtask

    task automatic add_feature(logic [INDEX_BITS-1:0] idx, t_smp c, t_smp p, t_smp n);
        t_label lab;
        lab = label_sample(c, p, n);
        if (lab.zero || lab.feat != FEAT_NONE)
            add_point(idx, c.r, KIND_FEATURE, lab.zero, lab.feat);
    endtask

    // Work out the points one accepted sample gives, in output order.
    task automatic predict_sample(t_in_item it);
        t_smp                  cur;
        t_out_item             tail;
        logic [INDEX_BITS-1:0] idx;
        logic                  last;
        int                    base;
        base   = expected_points.size();
        idx    = in_sweep ? next_index : '0;
        cur.v  = CMP_BITS'(it.sample_value);
        cur.s  = CMP_BITS'(it.sample_slope);
        cur.r  = it.report_value;
        cur.ok = it.sample_valid;
        last   = it.sweep_end || (idx == LAST_INDEX);

        if (idx == '0)
            add_point('0, cur.r, KIND_START, 1'b0, FEAT_NONE);
        else
            add_feature(idx - 1'b1, prev_smp,
                        (idx == INDEX_BITS'(1)) ? prev_smp : older_smp, cur);

        if (last) begin
            add_feature(idx, cur, (idx == '0) ? cur : prev_smp, cur);
            add_point(idx, cur.r, KIND_END, 1'b0, FEAT_NONE);
            in_sweep   = 1'b0;
            next_index = '0;
        end else begin
            in_sweep   = 1'b1;
            next_index = idx + 1'b1;
        end

        older_smp = prev_smp;
        prev_smp  = cur;

        if (expected_points.size() > base) begin
            tail = expected_points.pop_back();
            tail.last_of_run = 1'b1;
            expected_points.push_back(tail);
        end
    endtask

    task automatic check_point(t_out_item got);
        t_out_item want;
        if (expected_points.size() == 0) begin
            fail_n++;
            if (fail_n <= 10)
                $display("unexpected point: index %0d value %h kind %0d zero %0d feat %0d last %0d",
                         got.point_index, got.point_value, got.point_kind, got.is_zero,
                         got.feature, got.last_of_run);
            return;
        end
        want = expected_points.pop_front();
        checked_n++;
        if (got.point_index !== want.point_index || got.point_value !== want.point_value ||
            got.point_kind !== want.point_kind || got.is_zero !== want.is_zero ||
            got.feature !== want.feature || got.last_of_run !== want.last_of_run) begin
            fail_n++;
            if (fail_n <= 10) begin
                $display("point mismatch #%0d", fail_n);
                $display("  want: index %0d value %h kind %0d zero %0d feat %0d last %0d",
                         want.point_index, want.point_value, want.point_kind, want.is_zero,
                         want.feature, want.last_of_run);
                $display("  got:  index %0d value %h kind %0d zero %0d feat %0d last %0d",
                         got.point_index, got.point_value, got.point_kind, got.is_zero,
                         got.feature, got.last_of_run);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            next_index = '0;
            in_sweep   = 1'b0;
            prev_smp   = '0;
            older_smp  = '0;
            zero_on    = 1'b1;
            infl_on    = 1'b0;
            expected_points.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INCLUDE_ZERO: begin
                        zero_on = i_cfg_data[0];
                    end
                    CFG_DETECT_INFLECTION: begin
                        infl_on = i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) predict_sample(i_in_data);
            if (i_out_valid && i_out_ready) check_point(i_out_data);
        end
        o_fail_count = fail_n;
        o_pending    = expected_points.size();
        o_checked    = checked_n;
    end

endmodule

// ===== bench/tb_top.sv =====
// Stimulus and verdict for the curve feature classifier. A point checker sits
// beside the block, predicts every result transaction and counts failures;
// this module only drives reset, samples, the result-side ready and the config port.
module tb_top;
    import cfc_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int QUIET_LIMIT   = 1000;  // cycles with no transaction at all
    localparam int HOLD_CYCLES   = 120;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 6;     // a sample with no result still occupies the stage
    localparam int PHASE_ITEMS   = 55;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    t_in_item                 in_data   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    t_out_item                out_data;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int checked;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holds_asked    = 0;
    int holds_done     = 0;
    int samples_sent   = 0;
    int quiet_cycles   = 0;

    always #HALF_PERIOD clk = ~clk;

    curve_feature_classifier_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    cfc_point_check point_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Watchdog: end the run if no transaction moves on either channel for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d points outstanding",
                         quiet_cycles, pending);
                $display("end of test: mismatches");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Result side: stall at random, or hold ready low for a long stretch on request
    // so that the block fills up and pushes back on the sample channel.
    initial begin
        forever begin
            @(negedge clk);
            if (holds_done != holds_asked) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds_done++;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Offer one sample: idle at random first, then hold valid and payload until taken.
    task automatic send_item(t_in_item it);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        samples_sent++;
    endtask

    task automatic send_sample(logic [31:0] v, logic [31:0] s, logic [31:0] r,
                               logic ok, logic last);
        t_in_item it;
        it.sample_value = v;
        it.sample_slope = s;
        it.report_value = r;
        it.sample_valid = ok;
        it.sweep_end    = last;
        send_item(it);
    endtask

    // Drop valid, wait for every predicted point, then let the stage empty.
    task automatic drain_points();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(logic zero_on, logic infl_on);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_INCLUDE_ZERO;
        cfg_data <= zero_on;
        @(negedge clk);
        cfg_idx  <= CFG_DETECT_INFLECTION;
        cfg_data <= infl_on;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Mostly tiny values so that ties, zeros and sign changes are common.
    function automatic logic [31:0] pick_word();
        int w;
        if ($urandom_range(0, 99) < 70) begin
            w = $urandom_range(0, 8);
            return 32'(w - 4);
        end
        return $urandom;
    endfunction

    // Random well-formed sweeps with a sprinkle of fully random samples.
    task automatic run_sweeps(int n_items);
        t_in_item it;
        int       count;
        int       len;
        int       roll;
        count = 0;
        while (count < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) len = 1;
            else if (roll < 80) len = $urandom_range(2, 8);
            else len = $urandom_range(9, 24);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) < 6) begin
                    // noise: every field random, the end flag too
                    it = {$urandom, $urandom, $urandom, 2'($urandom)};
                end else begin
                    it.sample_value = pick_word();
                    it.sample_slope = pick_word();
                    it.report_value = $urandom;
                    it.sample_valid = ($urandom_range(0, 99) < 85);
                    it.sweep_end    = (k == len - 1);
                end
                send_item(it);
                count++;
            end
        end
    endtask

    initial begin
        int idle_mix[4][2];
        int cfg_mix[4][2];
        idle_mix = '{'{0, 0}, '{49, 0}, '{0, 49}, '{32, 32}};
        cfg_mix  = '{'{1, 1}, '{0, 0}, '{1, 0}, '{0, 1}};

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        set_config(1'b1, 1'b1);

        // single-sample sweeps: valid, invalid, and a zero value classified against itself
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b1);
        send_sample(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1, 1'b1);

        // value extremes, strict max and min, zero and sign changes
        send_sample(32'h8000_0000, 32'h0000_0001, 32'h1111_1111, 1'b1, 1'b0);
        send_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h2222_2222, 1'b1, 1'b0);
        send_sample(32'h8000_0000, 32'h0000_0003, 32'h3333_3333, 1'b1, 1'b0);
        send_sample(32'h0000_0000, 32'h0000_0002, 32'h4444_4444, 1'b1, 1'b0);
        send_sample(32'h0000_0005, 32'h0000_0007, 32'h5555_5555, 1'b1, 1'b0);
        send_sample(32'hFFFF_FFFD, 32'h0000_0001, 32'h6666_6666, 1'b1, 1'b0);
        send_sample(32'h0000_0004, 32'h0000_0004, 32'h7777_7777, 1'b1, 1'b1);

        // gaps: max after a gap, min before a gap, a sample isolated between gaps
        send_sample(32'h0000_0003, 32'h0000_0000, 32'hA000_0000, 1'b1, 1'b0);
        send_sample(32'h0000_0009, 32'h0000_0000, 32'hA000_0001, 1'b0, 1'b0);
        send_sample(32'h0000_0007, 32'h0000_0000, 32'hA000_0002, 1'b1, 1'b0);
        send_sample(32'h0000_0002, 32'h0000_0000, 32'hA000_0003, 1'b1, 1'b0);
        send_sample(32'h0000_0008, 32'h0000_0000, 32'hA000_0004, 1'b0, 1'b0);
        send_sample(32'h0000_0001, 32'h0000_0000, 32'hA000_0005, 1'b1, 1'b0);
        send_sample(32'h0000_0006, 32'h0000_0000, 32'hA000_0006, 1'b0, 1'b1);

        // monotonic values with a slope peak: inflection
        send_sample(32'h0001_0000, 32'h0000_0001, 32'hB000_0000, 1'b1, 1'b0);
        send_sample(32'h0002_0000, 32'h0000_0009, 32'hB000_0001, 1'b1, 1'b0);
        send_sample(32'h0003_0000, 32'h0000_0002, 32'hB000_0002, 1'b1, 1'b0);
        send_sample(32'h0004_0000, 32'h0000_0003, 32'hB000_0003, 1'b1, 1'b1);
        drain_points();

        // random phases, each with its own idle mix and config setting
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_mix[ph][0];
            recv_stall_pct = idle_mix[ph][1];
            set_config(cfg_mix[ph][0][0], cfg_mix[ph][1][0]);
            if (ph == 0) holds_asked++;
            run_sweeps(PHASE_ITEMS);
            drain_points();
        end

        $display("summary: %0d samples driven, %0d points checked, %0d failures",
                 samples_sent, checked, fail_count);
        $display("covered: directed corners, four idle mixes with config changes, a long hold-off");
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cfc_pkg.sv
rtl/cfc_front.sv
rtl/cfc_classify.sv
rtl/curve_feature_classifier_unit.sv
bench/cfc_point_check.sv
bench/tb_top.sv
